[hw/rtl/record_tlv_byte_deserializer_defines.svh]
// Assertion macros shared by the RTL.
`ifndef RECORD_TLV_BYTE_DESERIALIZER_DEFINES_SVH
`define RECORD_TLV_BYTE_DESERIALIZER_DEFINES_SVH
// Check that a condition implies a consequence in the next cycle.
`define RTB_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);
// Check that a condition implies a consequence in the same cycle.
`define RTB_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);
`endif

[hw/rtl/rtb_pkg.sv]
// ----------------------------------------------------------------------------
// rtb_pkg
// Shared types and constants of the record TLV byte deserializer.
// ----------------------------------------------------------------------------
package rtb_pkg;
   localparam int FieldLimit = 64;
   localparam int HeaderBytes = 16;
   localparam int QueueDepth = 2;
   localparam int QueuePtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntBits = $clog2(QueueDepth + 1);

   typedef logic [QueuePtrBits-1:0] qptr_type;
   typedef logic [QueueCntBits-1:0] qcnt_type;

   localparam logic [2:0] KIND_HEADER = 3'd0;
   localparam logic [2:0] KIND_SCALAR = 3'd1;
   localparam logic [2:0] KIND_START  = 3'd2;
   localparam logic [2:0] KIND_BYTE   = 3'd3;
   localparam logic [2:0] KIND_ERROR  = 3'd4;

   localparam logic [2:0] ERR_TRUNC   = 3'd0;
   localparam logic [2:0] ERR_FIELDS  = 3'd1;
   localparam logic [2:0] ERR_TYPE    = 3'd2;
   localparam logic [2:0] ERR_STRING  = 3'd3;
   localparam logic [2:0] ERR_BLOB    = 3'd4;

   localparam logic [2:0] CSR_MAX_FIELDS = 3'd0;
   localparam logic [2:0] CSR_MAX_STRING = 3'd1;
   localparam logic [2:0] CSR_MAX_BLOB   = 3'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [5:0]  field_index;
      logic [2:0]  col_type;
      logic [63:0] value;
      logic [31:0] table_tag;
      logic [6:0]  field_total;
      logic [2:0]  error_code;
      logic        record_end;
      logic [31:0] total_length;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      rsp_type     rsp;
   } slot_type;

   typedef struct packed {
      logic [6:0]  max_fields;
      logic [15:0] max_string_len;
      logic [31:0] blob_len_limit;
   } cfg_type;
endpackage

[hw/rtl/rtb_req_if.sv]
// ----------------------------------------------------------------------------
// rtb_req_if
// Byte input channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rtb_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        buffer_end;
   modport source (output valid, data_byte, buffer_end, input ready);
   modport sink (input valid, data_byte, buffer_end, output ready);
endinterface

[hw/rtl/rtb_rsp_if.sv]
// ----------------------------------------------------------------------------
// rtb_rsp_if
// Result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rtb_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [5:0]  field_index;
   logic [2:0]  col_type;
   logic [63:0] value;
   logic [31:0] table_tag;
   logic [6:0]  field_total;
   logic [2:0]  error_code;
   logic        record_end;
   logic [31:0] total_length;
   modport source (output valid, kind, field_index, col_type, value, table_tag,
                   field_total, error_code, record_end, total_length, input ready);
   modport sink (input valid, kind, field_index, col_type, value, table_tag,
                 field_total, error_code, record_end, total_length, output ready);
endinterface

[hw/rtl/rtb_parser.sv]
// ----------------------------------------------------------------------------
// rtb_parser
// Front part: parse one byte per cycle while step is high, producing at most one result slot.
// ----------------------------------------------------------------------------
module rtb_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  rtb_pkg::req_type   req,
   input  rtb_pkg::cfg_type   cfg,
   output rtb_pkg::slot_type  slot
);
   typedef enum logic [2:0] {
      PH_HEADER, PH_TYPE, PH_VALUE, PH_LENGTH, PH_PAYLOAD, PH_IGNORE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  biw_ff, biw_in;
   logic [63:0] shift_ff, shift_in;
   logic [63:0] row_ff, row_in;
   logic [31:0] tab_ff, tab_in;
   logic [6:0]  fexp_ff, fexp_in;
   logic [6:0]  fdone_ff, fdone_in;
   logic [2:0]  ctype_ff, ctype_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] count_ff, count_in;

   logic [3:0]  biw_n;
   logic [31:0] count_n;
   logic [31:0] w4;
   logic [15:0] w2;
   logic        have, err;
   logic [2:0]  ecode;
   rtb_pkg::rsp_type r;

   always_comb begin
      phase_in = phase_ff; biw_in = biw_ff; shift_in = shift_ff; row_in = row_ff;
      tab_in = tab_ff; fexp_in = fexp_ff; fdone_in = fdone_ff; ctype_in = ctype_ff;
      left_in = left_ff; count_in = count_ff;
      have = 1'b0; err = 1'b0; ecode = rtb_pkg::ERR_TRUNC;
      r = '0;
      biw_n = biw_ff + 4'd1;
      count_n = count_ff + 32'd1;
      shift_in = {req.data_byte, shift_ff[63:8]};
      w4 = shift_in[63:32];
      w2 = shift_in[63:48];
      if (phase_ff != PH_IGNORE) begin
         count_in = count_n;
         biw_in = biw_n;
      end else begin
         shift_in = shift_ff;
      end
      case (phase_ff)
         PH_HEADER: begin
            if (biw_n == 4'd8) row_in = shift_in;
            else if (biw_n == 4'd12) tab_in = w4;
            else if (biw_n == 4'd0) begin
               // sixteenth header byte: counter wraps
               if (w4 > {25'd0, cfg.max_fields} || w4 > 32'(rtb_pkg::FieldLimit)) begin
                  err = 1'b1; ecode = rtb_pkg::ERR_FIELDS;
               end else begin
                  fexp_in = w4[6:0]; fdone_in = '0; ctype_in = '0;
                  r.kind = rtb_pkg::KIND_HEADER;
                  r.value = row_ff; r.table_tag = tab_ff; r.field_total = w4[6:0];
                  have = 1'b1;
                  if (w4 == 32'd0) begin
                     r.record_end = 1'b1; r.total_length = count_n;
                     phase_in = PH_IGNORE;
                  end else begin
                     phase_in = PH_TYPE; biw_in = '0;
                  end
               end
            end
         end
         PH_TYPE: begin
            if (biw_n == 4'd4) begin
               biw_in = '0;
               if (w4 > 32'd6) begin
                  ctype_in = '0; err = 1'b1; ecode = rtb_pkg::ERR_TYPE;
               end else begin
                  ctype_in = w4[2:0];
                  phase_in = (w4 <= 32'd4) ? PH_VALUE : PH_LENGTH;
               end
            end
         end
         PH_VALUE: begin
            if ((ctype_ff <= 3'd1 && biw_n == 4'd8) || (ctype_ff == 3'd2 && biw_n == 4'd4)
                || (ctype_ff >= 3'd3 && biw_n == 4'd1)) begin
               r.kind = rtb_pkg::KIND_SCALAR;
               case (ctype_ff)
                  3'd0, 3'd1: r.value = shift_in;
                  3'd2:       r.value = {32'd0, w4};
                  3'd3:       r.value = {56'd0, req.data_byte};
                  default:    r.value = {63'd0, |req.data_byte};
               endcase
               have = 1'b1;
            end
         end
         PH_LENGTH: begin
            if ((ctype_ff == 3'd5 && biw_n == 4'd2) || (ctype_ff != 3'd5 && biw_n == 4'd4)) begin
               if (ctype_ff == 3'd5 && w2 > cfg.max_string_len) begin
                  err = 1'b1; ecode = rtb_pkg::ERR_STRING;
               end else if (ctype_ff != 3'd5 && w4 > cfg.blob_len_limit) begin
                  err = 1'b1; ecode = rtb_pkg::ERR_BLOB;
               end else begin
                  left_in = (ctype_ff == 3'd5) ? {16'd0, w2} : w4;
                  r.kind = rtb_pkg::KIND_START; r.value = {32'd0, left_in};
                  have = 1'b1;
                  phase_in = (left_in == 32'd0) ? PH_VALUE : PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            r.kind = rtb_pkg::KIND_BYTE; r.value = {56'd0, req.data_byte};
            have = 1'b1;
            left_in = left_ff - 32'd1;
            phase_in = (left_in == 32'd0) ? PH_VALUE : PH_PAYLOAD;
         end
         default: ;
      endcase
      r.field_index = fdone_ff[5:0];
      r.col_type = (phase_ff == PH_HEADER) ? 3'd0 : ctype_ff;
      // finish field: scalar, empty payload or last payload byte
      if (have && r.kind != rtb_pkg::KIND_HEADER && phase_in == PH_VALUE
          && !(phase_ff == PH_VALUE && 1'b0)) begin
         if (phase_ff == PH_VALUE || phase_ff == PH_LENGTH || phase_ff == PH_PAYLOAD) begin
            if (phase_ff != PH_VALUE || r.kind == rtb_pkg::KIND_SCALAR) begin
               fdone_in = fdone_ff + 7'd1;
               if (fdone_in >= fexp_ff) begin
                  r.record_end = 1'b1; r.total_length = count_n;
                  phase_in = PH_IGNORE;
               end else begin
                  phase_in = PH_TYPE; biw_in = '0;
               end
            end
         end
      end
      if (!err && req.buffer_end && phase_ff != PH_IGNORE && phase_in != PH_IGNORE) begin
         err = 1'b1; ecode = rtb_pkg::ERR_TRUNC;
         if (phase_in == PH_HEADER || phase_in == PH_TYPE) ctype_in = '0;
      end
      if (err) begin
         r = '0;
         r.kind = rtb_pkg::KIND_ERROR;
         r.field_index = fdone_in[5:0];
         r.col_type = ctype_in;
         r.error_code = ecode;
         phase_in = PH_IGNORE;
         have = 1'b1;
      end
      if (req.buffer_end) begin
         phase_in = PH_HEADER; biw_in = '0; shift_in = '0; row_in = '0; tab_in = '0;
         fexp_in = '0; fdone_in = '0; ctype_in = '0; left_in = '0; count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER; biw_ff <= '0; shift_ff <= '0; row_ff <= '0;
         tab_ff <= '0; fexp_ff <= '0; fdone_ff <= '0; ctype_ff <= '0;
         left_ff <= '0; count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; biw_ff <= biw_in; shift_ff <= shift_in; row_ff <= row_in;
         tab_ff <= tab_in; fexp_ff <= fexp_in; fdone_ff <= fdone_in; ctype_ff <= ctype_in;
         left_ff <= left_in; count_ff <= count_in;
      end
   end

   assign slot.valid = step && have && phase_ff != PH_IGNORE;
   assign slot.rsp = r;
endmodule

[hw/rtl/rtb_queue.sv]
// ----------------------------------------------------------------------------
// rtb_queue
// Back part: small result queue that drives the result channel.
// ----------------------------------------------------------------------------
module rtb_queue (
   input  logic               clock,
   input  logic               reset,
   input  rtb_pkg::slot_type  slot,
   output logic               has_room,
   output logic               out_valid,
   input  logic               out_ready,
   output rtb_pkg::rsp_type   out_rsp
);
   rtb_pkg::rsp_type  mem_ff [rtb_pkg::QueueDepth];
   rtb_pkg::qptr_type wp_ff, wp_in, rp_ff, rp_in;
   rtb_pkg::qcnt_type cnt_ff, cnt_in;
   logic              pop;

   assign pop = out_valid && out_ready;
   assign out_valid = cnt_ff != '0;
   assign out_rsp = mem_ff[rp_ff];
   assign has_room = cnt_ff != rtb_pkg::qcnt_type'(rtb_pkg::QueueDepth) || out_ready;

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (slot.valid) begin
         wp_in = (wp_ff == rtb_pkg::qptr_type'(rtb_pkg::QueueDepth - 1)) ? '0
                 : wp_ff + rtb_pkg::qptr_type'(1);
      end
      if (pop) begin
         rp_in = (rp_ff == rtb_pkg::qptr_type'(rtb_pkg::QueueDepth - 1)) ? '0
                 : rp_ff + rtb_pkg::qptr_type'(1);
      end
      cnt_in = cnt_ff + rtb_pkg::qcnt_type'(slot.valid) - rtb_pkg::qcnt_type'(pop);
   end

   always_ff @(posedge clock) begin
      if (slot.valid) mem_ff[wp_ff] <= slot.rsp;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule

[hw/rtl/record_tlv_byte_deserializer.sv]
// ----------------------------------------------------------------------------
// record_tlv_byte_deserializer
// Byte-serial parser of little-endian typed records.
// ----------------------------------------------------------------------------
// Usage: feed the buffer one byte per item on req (data_byte, buffer_end marks
// the last byte). Results leave on rsp: header, scalar values, payload starts,
// payload bytes and errors, at most one per input byte.
// Throughput: one byte per cycle while the queue has room (req_ready high).
// With the queue empty, a result is visible on rsp in the cycle after its
// byte is taken.
// A two-entry queue separates parser and receiver: while the receiver stalls,
// the parser keeps taking bytes until the queue is full, then drops req_ready.
// Bytes after a completed record or an error produce nothing until buffer_end.
// Reset (synchronous, active high) empties the queue, returns the parser to
// the header and loads the registers with max_fields 64, max_string_len 255
// and blob_len_limit 4096. Write csr_ registers only while the block is idle.
// ----------------------------------------------------------------------------
`include "record_tlv_byte_deserializer_defines.svh"
module record_tlv_byte_deserializer (
   input  logic          clock,
   input  logic          reset,
   rtb_req_if.sink       req,
   rtb_rsp_if.source     rsp,
   input  logic          csr_write_enable,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_write_data
);
   rtb_pkg::cfg_type  cfg_ff;
   rtb_pkg::req_type  byte_in;
   rtb_pkg::slot_type slot;
   rtb_pkg::rsp_type  out_rsp;
   logic has_room, step;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_fields <= 7'd64;
         cfg_ff.max_string_len <= 16'd255;
         cfg_ff.blob_len_limit <= 32'd4096;
      end else if (csr_write_enable) begin
         case ({1'b0, csr_index})
            rtb_pkg::CSR_MAX_FIELDS: cfg_ff.max_fields <= csr_write_data[6:0];
            rtb_pkg::CSR_MAX_STRING: cfg_ff.max_string_len <= csr_write_data[15:0];
            rtb_pkg::CSR_MAX_BLOB:   cfg_ff.blob_len_limit <= csr_write_data;
            default: ;
         endcase
      end
   end

   // advance the parser whenever the queue can take a result
   assign req.ready = has_room;
   assign step = req.valid && has_room;
   assign byte_in.data_byte = req.data_byte;
   assign byte_in.buffer_end = req.buffer_end;

   rtb_parser u_parser (
      .clock (clock), .reset (reset), .step (step), .req (byte_in),
      .cfg (cfg_ff), .slot (slot)
   );

   rtb_queue u_queue (
      .clock (clock), .reset (reset), .slot (slot), .has_room (has_room),
      .out_valid (rsp.valid), .out_ready (rsp.ready), .out_rsp (out_rsp)
   );

   assign rsp.kind = out_rsp.kind;
   assign rsp.field_index = out_rsp.field_index;
   assign rsp.col_type = out_rsp.col_type;
   assign rsp.value = out_rsp.value;
   assign rsp.table_tag = out_rsp.table_tag;
   assign rsp.field_total = out_rsp.field_total;
   assign rsp.error_code = out_rsp.error_code;
   assign rsp.record_end = out_rsp.record_end;
   assign rsp.total_length = out_rsp.total_length;

   `RTB_ASSERT_NOW(a_err_no_end, clock, reset, rsp.valid && rsp.kind == rtb_pkg::KIND_ERROR,
      !rsp.record_end, "error result marked record end")
   `RTB_ASSERT_NEXT(a_result_shown, clock, reset, slot.valid, rsp.valid,
      "queued result not presented")
   `RTB_ASSERT_NOW(a_room_stall, clock, reset, !req.ready, rsp.valid && !rsp.ready,
      "input stalled without receiver stall")
endmodule
